[sv/osm_pkg.sv]
// osm_pkg: shared constants, op codes, entry type and key compare for the
// offset order statistic multiset. No dependencies.
package osm_pkg;
    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = IDX_W + 1;
    localparam int MULT_W   = 20;
    localparam logic [MULT_W-1:0] MULT_MAX = {MULT_W{1'b1}};

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_SUB    = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    typedef struct packed {
        logic [31:0]       key;
        logic [MULT_W-1:0] mult;
    } entry_t;

    // signed compare of two's complement keys
    function automatic logic key_less(input logic [31:0] a, input logic [31:0] b);
        key_less = $signed(a) < $signed(b);
    endfunction
endpackage

[sv/osm_store.sv]
// osm_store: entry memory, one write and one registered read port.
// Depends on osm_pkg.
module osm_store
    import osm_pkg::*;
(
    input  logic             clk,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output entry_t           rdata,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  entry_t           wdata
);
    entry_t mem [CAPACITY];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[sv/offset_order_statistic_multiset.sv]
// offset_order_statistic_multiset: sorted multiset in a ring-buffered
// memory, driven by a command sequencer. Depends on osm_pkg, osm_store.
//
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------
// command  | start / busy         | op, value
// result   | done (1-cycle pulse) | kth_value, found, removed_total, dropped
// config   | cfg_we               | cfg_wdata (min_level)
//
// Entries sit in ascending key order starting at a ring head, so pruning only
// advances the head. Each memory visit is a read state, then a compare or
// write state: insert scans up from the head and, for a new key, shifts the
// tail up; prune evicts from the head while keys lie below min_level; query
// scans down from the largest key until the rank is met; add moves the offset.
// Reset clears the count, head, offset, total and min_level; the memory is not
// cleared since only entries below the count are ever read.
// done pulses once per item; the receiver cannot stall it.
module offset_order_statistic_multiset
    import osm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic [30:0]        value,
    input  logic               cfg_we,
    input  logic [30:0]        cfg_wdata,
    output logic               done,
    output logic signed [31:0] kth_value,
    output logic               found,
    output logic [31:0]        removed_total,
    output logic               dropped
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_I_RD  = 4'd1;
    localparam logic [3:0] ST_I_CMP = 4'd2;
    localparam logic [3:0] ST_S_RD  = 4'd3;
    localparam logic [3:0] ST_S_WR  = 4'd4;
    localparam logic [3:0] ST_I_PUT = 4'd5;
    localparam logic [3:0] ST_P_RD  = 4'd6;
    localparam logic [3:0] ST_P_CMP = 4'd7;
    localparam logic [3:0] ST_Q_RD  = 4'd8;
    localparam logic [3:0] ST_Q_CMP = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;
    localparam logic [3:0] ST_I_NEW = 4'd11;

    logic [3:0]       state_reg, state_next;
    logic [30:0]      min_level_reg;
    logic [31:0]      offset_reg, offset_next;
    logic [31:0]      total_reg, total_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] idx_reg, idx_next;   // logical index (scan / shift)
    logic [CNT_W-1:0] pos_reg, pos_next;   // insert slot
    logic [31:0]      key_reg, key_next;   // insert key, prune threshold
    logic [30:0]      k_reg, k_next;
    logic [31:0]      seen_reg, seen_next;
    logic [31:0]      kval_reg, kval_next;
    logic             found_reg, found_next;
    logic             drop_reg, drop_next;

    logic             re, we;
    logic [IDX_W-1:0] raddr, waddr;
    entry_t           rdata, wdata;
    logic [31:0]      seen_sum;

    osm_store u_store (
        .clk   (clk),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata)
    );

    assign seen_sum = seen_reg + {{(32-MULT_W){1'b0}}, rdata.mult};

    always_comb
    begin
        state_next = state_reg;
        offset_next = offset_reg;
        total_next = total_reg;
        used_next = used_reg;
        head_next = head_reg;
        idx_next = idx_reg;
        pos_next = pos_reg;
        key_next = key_reg;
        k_next = k_reg;
        seen_next = seen_reg;
        kval_next = kval_reg;
        found_next = found_reg;
        drop_next = drop_reg;
        re = 1'b0;
        we = 1'b0;
        raddr = head_reg + idx_reg[IDX_W-1:0];
        waddr = head_reg + idx_reg[IDX_W-1:0];
        wdata = rdata;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kval_next = '0;
                    found_next = 1'b0;
                    drop_next = 1'b0;
                    idx_next = '0;
                    seen_next = '0;
                    k_next = value;
                    state_next = ST_DONE;
                    case (op)
                        OP_INSERT:
                        begin
                            key_next = {1'b0, value} - offset_reg;
                            if (value >= min_level_reg)
                            begin
                                state_next = ST_I_RD;
                            end
                        end
                        OP_ADD:
                        begin
                            offset_next = offset_reg + {1'b0, value};
                        end
                        OP_SUB:
                        begin
                            offset_next = offset_reg - {1'b0, value};
                            key_next = {1'b0, min_level_reg} - offset_next;
                            state_next = ST_P_RD;
                        end
                        OP_QUERY:
                        begin
                            idx_next = used_reg;
                            if (value != '0)
                            begin
                                state_next = ST_Q_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_I_RD:
            begin
                if (idx_reg == used_reg)
                begin
                    state_next = ST_I_NEW;
                end
                else
                begin
                    re = 1'b1;
                    state_next = ST_I_CMP;
                end
            end
            ST_I_CMP:
            begin
                if (key_less(rdata.key, key_reg))
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_I_RD;
                end
                else if (rdata.key == key_reg)
                begin
                    if (rdata.mult == MULT_MAX)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        we = 1'b1;
                        wdata.key = rdata.key;
                        wdata.mult = rdata.mult + 1'b1;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_I_NEW;
                end
            end
            ST_I_NEW:
            begin
                // new distinct key goes at idx; shift the tail up by one
                if (used_reg == CNT_W'(CAPACITY))
                begin
                    drop_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    pos_next = idx_reg;
                    idx_next = used_reg;
                    state_next = ST_S_RD;
                end
            end
            ST_S_RD:
            begin
                if (idx_reg == pos_reg)
                begin
                    state_next = ST_I_PUT;
                end
                else
                begin
                    re = 1'b1;
                    raddr = head_reg + idx_reg[IDX_W-1:0] - 1'b1;
                    state_next = ST_S_WR;
                end
            end
            ST_S_WR:
            begin
                we = 1'b1;
                wdata = rdata;
                idx_next = idx_reg - 1'b1;
                state_next = ST_S_RD;
            end
            ST_I_PUT:
            begin
                we = 1'b1;
                waddr = head_reg + pos_reg[IDX_W-1:0];
                wdata.key = key_reg;
                wdata.mult = MULT_W'(1);
                used_next = used_reg + 1'b1;
                state_next = ST_DONE;
            end
            ST_P_RD:
            begin
                raddr = head_reg;
                if (used_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    re = 1'b1;
                    state_next = ST_P_CMP;
                end
            end
            ST_P_CMP:
            begin
                if (key_less(rdata.key, key_reg))
                begin
                    total_next = total_reg + {{(32-MULT_W){1'b0}}, rdata.mult};
                    head_next = head_reg + 1'b1;
                    used_next = used_reg - 1'b1;
                    state_next = ST_P_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_Q_RD:
            begin
                // scan from the largest key downward
                raddr = head_reg + idx_reg[IDX_W-1:0] - 1'b1;
                if (idx_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    re = 1'b1;
                    idx_next = idx_reg - 1'b1;
                    state_next = ST_Q_CMP;
                end
            end
            ST_Q_CMP:
            begin
                seen_next = seen_sum;
                if (seen_sum >= {1'b0, k_reg})
                begin
                    found_next = 1'b1;
                    kval_next = rdata.key + offset_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_Q_RD;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            min_level_reg <= '0;
            offset_reg <= '0;
            total_reg <= '0;
            used_reg <= '0;
            head_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                min_level_reg <= cfg_wdata;
            end
            offset_reg <= offset_next;
            total_reg <= total_next;
            used_reg <= used_next;
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        pos_reg <= pos_next;
        key_reg <= key_next;
        k_reg <= k_next;
        seen_reg <= seen_next;
        kval_reg <= kval_next;
        found_reg <= found_next;
        drop_reg <= drop_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);
    assign kth_value = $signed(kval_reg);
    assign found = found_reg;
    assign removed_total = total_reg;
    assign dropped = drop_reg;
endmodule
